[hw/rtl/dced_pkg.sv]
// Shared types, constants and key code tables of the dial click event detector.
package dced_pkg;

    // Number of samples held per channel and number of dials in use.
    localparam int HISTORY_DEPTH = 4;
    localparam int DIAL_COUNT    = 6;

    // Fixed channel layout: six dial slots, then the two push switches.
    localparam int DIAL_SLOTS    = 6;
    localparam int CHANNELS      = 8;
    localparam int CH_W          = 3;
    localparam logic [CH_W-1:0] CH_SWITCH_ONE = 3'd6;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Key codes: forward and reverse per dial, release per switch.
    localparam logic [7:0] FWD_CODE [0:DIAL_SLOTS-1] = '{"W", "A", "Z", "R", "F", "V"};
    localparam logic [7:0] REV_CODE [0:DIAL_SLOTS-1] = '{"Q", "S", "X", "E", "D", "C"};
    localparam logic [7:0] REL_CODE [0:1]            = '{"T", "G"};

    // One classified sample tick: channels that fired and dial directions.
    typedef struct packed {
        logic [CHANNELS-1:0]   fire;
        logic [DIAL_SLOTS-1:0] fwd;
    } tick_rec_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Key code for an event on a channel with the given direction.
    function automatic logic [7:0] key_code_of(logic [CH_W-1:0] ch, logic fwd);
        logic [7:0] code;
        if (ch >= CH_SWITCH_ONE)
        begin
            code = REL_CODE[ch[0]];
        end
        else if (fwd)
        begin
            code = FWD_CODE[ch];
        end
        else
        begin
            code = REV_CODE[ch];
        end
        return code;
    endfunction

endpackage

[hw/rtl/dced_front.sv]
// Front part: sample histories per channel and classification of each tick.
module dced_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [5:0]                 clock_levels,
    input  logic [5:0]                 direction_levels,
    input  logic [1:0]                 switch_pins,
    input  dced_pkg::queue_status_t    q_status,
    output logic                       q_push,
    output dced_pkg::tick_rec_t        q_wdata
);

    localparam int HD = dced_pkg::HISTORY_DEPTH;

    logic [HD-1:0] level_hist_reg [0:dced_pkg::CHANNELS-1];
    logic [HD-1:0] level_hist_next [0:dced_pkg::CHANNELS-1];
    logic [HD-1:0] dir_hist_reg [0:dced_pkg::DIAL_COUNT-1];
    logic [HD-1:0] dir_hist_next [0:dced_pkg::DIAL_COUNT-1];
    logic [dced_pkg::CHANNELS-1:0] sample;
    logic accept;

    // An item is taken whenever the queue has room.
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Switches are inverted so that a pressed switch reads as one.
    assign sample = {~switch_pins[1], ~switch_pins[0], clock_levels};

    // New histories and the classification of this tick.
    always_comb
    begin
        q_wdata = '0;
        for (int i = 0; i < dced_pkg::CHANNELS; i++)
        begin
            if (i < dced_pkg::DIAL_COUNT || i >= dced_pkg::DIAL_SLOTS)
            begin
                level_hist_next[i] = {level_hist_reg[i][HD-2:0], sample[i]};
                q_wdata.fire[i] = (level_hist_next[i][1:0] == 2'b00) &&
                                  (&level_hist_next[i][HD-1:2]);
            end
            else
            begin
                level_hist_next[i] = level_hist_reg[i];
            end
        end
        for (int i = 0; i < dced_pkg::DIAL_COUNT; i++)
        begin
            dir_hist_next[i] = {dir_hist_reg[i][HD-2:0], direction_levels[i]};
            q_wdata.fwd[i] = ($countones(dir_hist_next[i]) >= HD / 2);
        end
    end

    // Only ticks that cause at least one event enter the queue.
    assign q_push = accept && (q_wdata.fire != '0);

    // History registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dced_pkg::CHANNELS; i++)
            begin
                level_hist_reg[i] <= '1;
            end
            for (int i = 0; i < dced_pkg::DIAL_COUNT; i++)
            begin
                dir_hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            level_hist_reg <= level_hist_next;
            dir_hist_reg   <= dir_hist_next;
        end
    end

endmodule

[hw/rtl/dced_queue.sv]
// Short queue of classified ticks between the front and the back.
module dced_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  dced_pkg::tick_rec_t     wdata,
    input  logic                    pop,
    output dced_pkg::tick_rec_t     rdata,
    output dced_pkg::queue_status_t status
);

    dced_pkg::tick_rec_t          entry_reg [0:dced_pkg::QUEUE_DEPTH-1];
    logic [dced_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [dced_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [dced_pkg::QCNT_W-1:0]  count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign status.full  = (count_reg == dced_pkg::QCNT_W'(dced_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hw/rtl/dced_back.sv]
// Back part: walks the fired channels of each tick and issues one event per cycle while the receiver takes them.
module dced_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dced_pkg::queue_status_t      q_status,
    input  dced_pkg::tick_rec_t          q_rdata,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dced_pkg::CH_W-1:0]    channel,
    output logic [7:0]                   key_code,
    output logic                         last_event
);

    logic [dced_pkg::CHANNELS-1:0]   mask_reg, mask_next;
    logic [dced_pkg::DIAL_SLOTS-1:0] fwd_reg, fwd_next;
    logic                            valid_reg, valid_next;
    logic [dced_pkg::CH_W-1:0]       ch_reg, ch_next;
    logic [7:0]                      code_reg, code_next;
    logic                            last_reg, last_next;
    logic [dced_pkg::CHANNELS-1:0]   src_mask;
    logic [dced_pkg::DIAL_SLOTS-1:0] src_fwd;
    logic [dced_pkg::CHANNELS-1:0]   rem_mask;
    logic                            sel_fwd;
    logic                            can_load;

    assign can_load = !valid_reg || out_ready;

    // Work from the tick in hand, or take the next one from the queue.
    always_comb
    begin
        q_pop    = 1'b0;
        src_mask = mask_reg;
        src_fwd  = fwd_reg;
        if (mask_reg == '0)
        begin
            src_mask = q_status.empty ? '0 : q_rdata.fire;
            src_fwd  = q_rdata.fwd;
            q_pop    = can_load && !q_status.empty;
        end
    end

    // Lowest fired channel goes out next.
    always_comb
    begin
        ch_next = '0;
        sel_fwd = 1'b0;
        for (int i = dced_pkg::CHANNELS - 1; i >= 0; i--)
        begin
            if (src_mask[i])
            begin
                ch_next = dced_pkg::CH_W'(i);
                sel_fwd = (i < dced_pkg::DIAL_SLOTS) ? src_fwd[i % dced_pkg::DIAL_SLOTS] : 1'b0;
            end
        end
        rem_mask  = src_mask & (src_mask - 1'b1);
        code_next = dced_pkg::key_code_of(ch_next, sel_fwd);
        last_next = (rem_mask == '0);
    end

    // Next values of the walk state and the output register.
    always_comb
    begin
        mask_next  = mask_reg;
        fwd_next   = fwd_reg;
        valid_next = valid_reg;
        if (can_load)
        begin
            mask_next  = rem_mask;
            fwd_next   = src_fwd;
            valid_next = (src_mask != '0);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fwd_reg <= fwd_next;
        if (can_load)
        begin
            ch_reg   <= ch_next;
            code_reg <= code_next;
            last_reg <= last_next;
        end
    end

    assign out_valid  = valid_reg;
    assign channel    = ch_reg;
    assign key_code   = code_reg;
    assign last_event = last_reg;

endmodule

[hw/rtl/dial_click_event_detector.sv]
// Top level of the dial click event detector: front, queue and back joined.
// The first event of a tick is held in the tick queue, then in the output register, before it is presented.
// Throughput: one item per cycle while the two-entry tick queue has room; the back
// issues one event per cycle while the receiver takes them.
// Reset: channel level histories go to all ones, direction histories to all zeros,
// the queue and the output register empty.
module dial_click_event_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [5:0] clock_levels, [11:6] direction_levels, [13:12] switch_pins, [15:14] zero
    input  logic [dced_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] channel, [10:3] key_code, [15:11] zero
    output logic [dced_pkg::M_DATA_W-1:0] m_tdata,
    // last_event
    output logic                          m_tlast
);

    dced_pkg::queue_status_t    q_status;
    dced_pkg::tick_rec_t        q_wdata;
    dced_pkg::tick_rec_t        q_rdata;
    logic                       q_push;
    logic                       q_pop;
    logic [dced_pkg::CH_W-1:0]  channel;
    logic [7:0]                 key_code;

    dced_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .clock_levels     (s_tdata[5:0]),
        .direction_levels (s_tdata[11:6]),
        .switch_pins      (s_tdata[13:12]),
        .q_status         (q_status),
        .q_push           (q_push),
        .q_wdata          (q_wdata)
    );

    dced_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    dced_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .channel    (channel),
        .key_code   (key_code),
        .last_event (m_tlast)
    );

    // Pack the result fields, padding to whole bytes.
    assign m_tdata = {5'b0, key_code, channel};

endmodule

[hw/rtl/dced_checker.sv]
// Port-level checks of the dial click event detector and their binding.
module dced_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dced_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Unused dial channels never report.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] < 3'(dced_pkg::DIAL_COUNT)) || (m_tdata[2:0] >= 3'd6))
        else $error("event on an unused dial channel");

    // Events of one tick come out in rising channel order.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (m_tdata[2:0] > $past(m_tdata[2:0])))
        else $error("events of a tick out of channel order");

    // A switch event always carries its release code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] >= 3'd6 |->
            m_tdata[10:3] == dced_pkg::REL_CODE[m_tdata[0]])
        else $error("switch event with a wrong key code");

endmodule

bind dial_click_event_detector dced_checker u_dced_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[sim/tb_dial_click_event_detector.sv]
// Self-checking testbench of the dial click event detector with its own click predictor.
module tb_dial_click_event_detector;

    timeunit 1ns;
    timeprecision 1ps;

    // Channel numbers of the push switches, after the six dial slots.
    localparam int DIAL_SLOTS    = 6;
    localparam int SWITCH_ONE_CH = 6;
    localparam int SWITCH_TWO_CH = 7;
    localparam int CHANNELS      = 8;

    // A channel fires on two older samples high and two newest samples low.
    localparam logic [3:0] CLICK_PATTERN = 4'b1100;

    // Key codes, dial 0 and switch one in the highest byte.
    localparam logic [47:0] FWD_KEYS     = "WAZRFV";
    localparam logic [47:0] REV_KEYS     = "QSXEDC";
    localparam logic [15:0] RELEASE_KEYS = "TG";

    localparam int MAX_GAP     = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0] channel;
        logic [7:0] key_code;
        logic       last_event;
    } click_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [5:0] clock_levels, [11:6] direction_levels, [13:12] switch_pins, [15:14] zero
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [2:0] channel, [10:3] key_code, [15:11] zero
    logic [15:0] m_tdata;
    logic        m_tlast;

    dial_click_event_detector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Predictor state: sample histories, bit 0 newest.
    logic [3:0] level_hist [CHANNELS];
    logic [3:0] dir_hist [DIAL_SLOTS];

    // Clicks still owed by the block, oldest first.
    click_event_t pending_clicks[$];

    int tx_max_gap = MAX_GAP;
    int rx_max_gap = MAX_GAP;
    logic rx_hold = 1'b0;
    int rx_gap = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int clicks_checked = 0;
    int fwd_clicks = 0;
    int rev_clicks = 0;
    int release_clicks = 0;

    // Random level generator state for the click sequences.
    logic [5:0] dial_levels = '1;
    logic [1:0] pin_levels = '1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run-time limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d clicks outstanding", cycle_count,
                     pending_clicks.size());
            $display("** dial_click_event_detector: FAILED **");
            $finish;
        end
    end

    // Works out the clicks of one sample tick and queues them.
    function automatic void predict_clicks(input logic [5:0] clk_lv, input logic [5:0] dir_lv,
                                           input logic [1:0] sw_pins);
        click_event_t tick_clicks[$];
        click_event_t ev;
        int ones;
        for (int ch = 0; ch < DIAL_SLOTS; ch++)
        begin
            if (ch < dced_pkg::DIAL_COUNT)
            begin
                level_hist[ch] = {level_hist[ch][2:0], clk_lv[ch]};
                dir_hist[ch]   = {dir_hist[ch][2:0], dir_lv[ch]};
            end
        end
        // Switches are active low, so a pressed switch is stored as 1.
        level_hist[SWITCH_ONE_CH] = {level_hist[SWITCH_ONE_CH][2:0], ~sw_pins[0]};
        level_hist[SWITCH_TWO_CH] = {level_hist[SWITCH_TWO_CH][2:0], ~sw_pins[1]};

        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if ((ch < DIAL_SLOTS && ch >= dced_pkg::DIAL_COUNT) ||
                level_hist[ch] != CLICK_PATTERN)
            begin
                continue;
            end
            ev.channel    = 3'(ch);
            ev.last_event = 1'b0;
            if (ch < DIAL_SLOTS)
            begin
                ones = $countones(dir_hist[ch]);
                if (ones >= 2)
                begin
                    ev.key_code = FWD_KEYS[8*(5-ch) +: 8];
                    fwd_clicks++;
                end
                else
                begin
                    ev.key_code = REV_KEYS[8*(5-ch) +: 8];
                    rev_clicks++;
                end
            end
            else
            begin
                ev.key_code = RELEASE_KEYS[8*(SWITCH_TWO_CH-ch) +: 8];
                release_clicks++;
            end
            tick_clicks.push_back(ev);
        end
        if (tick_clicks.size() > 0)
        begin
            tick_clicks[tick_clicks.size()-1].last_event = 1'b1;
        end
        foreach (tick_clicks[i])
        begin
            pending_clicks.push_back(tick_clicks[i]);
        end
    endfunction

    // Receiver: a random wait before each click, plus the long hold when asked.
    always @(posedge clk)
    begin
        int gap;
        if (!rst_n || rx_hold)
        begin
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            gap = $urandom_range(0, rx_max_gap);
            m_tready <= (gap == 0);
            rx_gap <= (gap == 0) ? 0 : gap - 1;
        end
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compares each accepted click with the oldest expected one.
    always @(posedge clk)
    begin
        click_event_t got;
        click_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.channel    = m_tdata[2:0];
            got.key_code   = m_tdata[10:3];
            got.last_event = m_tlast;
            if (pending_clicks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: unexpected click ch=%0d key=%c last=%0b", $realtime,
                             got.channel, got.key_code, got.last_event);
                end
            end
            else
            begin
                want = pending_clicks.pop_front();
                clicks_checked++;
                if (got.channel !== want.channel || got.key_code !== want.key_code ||
                    got.last_event !== want.last_event)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: expected ch=%0d key=%c last=%0b, got ch=%0d key=%c last=%0b",
                                 $realtime, want.channel, want.key_code, want.last_event,
                                 got.channel, got.key_code, got.last_event);
                    end
                end
            end
        end
    end

    // Offers one sample tick after a random gap and returns at its acceptance edge.
    // The valid stays high so that a following item can follow without a gap.
    task automatic send_tick(input logic [5:0] clk_lv, input logic [5:0] dir_lv,
                             input logic [1:0] sw_pins);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, sw_pins, dir_lv, clk_lv};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_clicks(clk_lv, dir_lv, sw_pins);
        ticks_sent++;
    endtask

    // Lowers the valid at the current edge and waits for every owed click.
    task automatic drain_clicks();
        s_tvalid <= 1'b0;
        while (pending_clicks.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Next tick of the random click generator: levels change in runs so
    // that clean clicks are common, with some ticks of pure noise.
    task automatic send_random_tick();
        logic [5:0] dir_lv;
        int density;
        if ($urandom_range(0, 99) < 15)
        begin
            send_tick(6'($urandom), 6'($urandom), 2'($urandom));
        end
        else
        begin
            for (int ch = 0; ch < DIAL_SLOTS; ch++)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    dial_levels[ch] = ~dial_levels[ch];
                end
            end
            for (int sw = 0; sw < 2; sw++)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    pin_levels[sw] = ~pin_levels[sw];
                end
            end
            density = $urandom_range(0, 4);
            for (int ch = 0; ch < DIAL_SLOTS; ch++)
            begin
                dir_lv[ch] = ($urandom_range(0, 3) < density);
            end
            send_tick(dial_levels, dir_lv, pin_levels);
        end
    endtask

    // Holds the receiver off for a number of cycles.
    task automatic hold_receiver(input int cycles);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // From reset every channel reads high, so two low ticks fire all eight.
    task automatic test_reset_clicks();
        send_tick(6'h00, 6'h3F, 2'b11);
        send_tick(6'h00, 6'h3F, 2'b11);
        send_tick(6'h00, 6'h00, 2'b11);
        send_tick(6'h00, 6'h00, 2'b00);
    endtask

    // Dials see zero to four direction ones over the click window.
    task automatic test_direction_majority();
        send_tick(6'h3F, 6'h1E, 2'b00);
        send_tick(6'h3F, 6'h3C, 2'b00);
        send_tick(6'h00, 6'h18, 2'b11);
        send_tick(6'h00, 6'h30, 2'b11);
    endtask

    // A lone dial, a lone switch and a bouncing level that must not fire.
    task automatic test_single_channels();
        send_tick(6'h20, 6'h20, 2'b11);
        send_tick(6'h20, 6'h00, 2'b11);
        send_tick(6'h00, 6'h20, 2'b11);
        send_tick(6'h00, 6'h00, 2'b11);
        send_tick(6'h00, 6'h00, 2'b01);
        send_tick(6'h00, 6'h00, 2'b01);
        send_tick(6'h00, 6'h00, 2'b11);
        send_tick(6'h00, 6'h00, 2'b11);
        send_tick(6'h01, 6'h01, 2'b11);
        send_tick(6'h00, 6'h01, 2'b11);
        send_tick(6'h01, 6'h01, 2'b11);
        send_tick(6'h00, 6'h01, 2'b11);
        drain_clicks();
    endtask

    // Random click traffic in bursts with different idling on both sides.
    task automatic test_random_clicks();
        for (int burst = 0; burst < 8; burst++)
        begin
            case (burst % 4)
                0:
                begin
                    tx_max_gap = 0;
                    rx_max_gap = 0;
                end
                1:
                begin
                    tx_max_gap = MAX_GAP;
                    rx_max_gap = MAX_GAP;
                end
                2:
                begin
                    tx_max_gap = 0;
                    rx_max_gap = MAX_GAP;
                end
                default:
                begin
                    tx_max_gap = MAX_GAP;
                    rx_max_gap = 0;
                end
            endcase
            repeat (36) send_random_tick();
        end
        tx_max_gap = MAX_GAP;
        rx_max_gap = MAX_GAP;
    endtask

    // The receiver stops for a long stretch while full ticks keep coming.
    task automatic test_backpressure();
        tx_max_gap = 0;
        fork
            hold_receiver(80);
        join_none
        for (int i = 0; i < 12; i++)
        begin
            send_tick(6'h3F, 6'($urandom), 2'b00);
            send_tick(6'h3F, 6'($urandom), 2'b00);
            send_tick(6'h00, 6'($urandom), 2'b11);
            send_tick(6'h00, 6'($urandom), 2'b11);
        end
        tx_max_gap = MAX_GAP;
    endtask

    // The sender pauses until every click has come out, then resumes.
    task automatic test_drain_pause();
        repeat (8) send_random_tick();
        drain_clicks();
        repeat (8) send_random_tick();
    endtask

    initial
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            level_hist[ch] = '1;
        end
        for (int ch = 0; ch < DIAL_SLOTS; ch++)
        begin
            dir_hist[ch] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_clicks();
        test_direction_majority();
        test_single_channels();
        test_random_clicks();
        test_backpressure();
        test_drain_pause();

        // Let the block settle after the last click before judging.
        drain_clicks();
        repeat (20) @(posedge clk);

        $display("Sent %0d sample ticks and checked %0d clicks: %0d forward, %0d reverse,",
                 ticks_sent, clicks_checked, fwd_clicks, rev_clicks);
        $display("%0d switch releases, with random idling and a long receiver stall.",
                 release_clicks);
        if (mismatches == 0 && pending_clicks.size() == 0)
        begin
            $display("** dial_click_event_detector: PASSED **");
        end
        else
        begin
            $display("%0d mismatches, %0d clicks never came", mismatches,
                     pending_clicks.size());
            $display("** dial_click_event_detector: FAILED **");
        end
        $finish;
    end

endmodule
